FILE: rtl/clint_pkg.sv
`timescale 1ns / 1ps

package clint_pkg;

    // Harts served by the block
    localparam int NUM_HARTS = 2;

    // Divider operand widths: widened cycle sum over cycles-per-microsecond
    localparam int DIVIDEND_W = 33;
    localparam int DIVISOR_W  = 32;

    // Operation codes carried in the kind field
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_READ      = 3'd1;
    localparam logic [2:0] KIND_WRITE     = 3'd2;
    localparam logic [2:0] KIND_SET_PEND  = 3'd3;
    localparam logic [2:0] KIND_CLR_PEND  = 3'd4;
    localparam logic [2:0] KIND_CHECK     = 3'd5;

    // Dense register map
    localparam logic [3:0] REG_TIME_LO = 4'd0;
    localparam logic [3:0] REG_TIME_HI = 4'd1;
    localparam logic [3:0] REG_CMP0_LO = 4'd2;
    localparam logic [3:0] REG_CMP0_HI = 4'd3;
    localparam logic [3:0] REG_CMP1_LO = 4'd4;
    localparam logic [3:0] REG_CMP1_HI = 4'd5;
    localparam logic [3:0] REG_SOFT0   = 4'd6;
    localparam logic [3:0] REG_SOFT1   = 4'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_CYCLES_PER_US = 2'd0;
    localparam logic [1:0] CFG_EXT_EN_HART0  = 2'd1;
    localparam logic [1:0] CFG_EXT_EN_HART1  = 2'd2;

    // Trap causes
    localparam logic [1:0] CAUSE_EXT   = 2'd0;
    localparam logic [1:0] CAUSE_SOFT  = 2'd1;
    localparam logic [1:0] CAUSE_TIMER = 2'd2;

    // Request into the divider
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

endpackage

FILE: rtl/clint_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module clint_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  clint_pkg::div_req_t                  req,
    output logic                                 done,
    output logic [clint_pkg::DIVIDEND_W-1:0]     quotient,
    output logic [clint_pkg::DIVISOR_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(clint_pkg::DIVIDEND_W + 1);

    logic                                busy_reg;
    logic                                done_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [clint_pkg::DIVIDEND_W-1:0]    quo_reg;
    logic [clint_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [clint_pkg::DIVISOR_W-1:0]     dvs_reg;

    logic [clint_pkg::DIVISOR_W:0]       shifted;
    logic [clint_pkg::DIVISOR_W:0]       diff;
    logic                                q_bit;
    logic [clint_pkg::DIVISOR_W-1:0]     rem_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[clint_pkg::DIVIDEND_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        q_bit    = (shifted >= {1'b0, dvs_reg});
        // partial remainder always ends below the divisor
        rem_next = q_bit ? diff[clint_pkg::DIVISOR_W-1:0]
                         : shifted[clint_pkg::DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(clint_pkg::DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[clint_pkg::DIVIDEND_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/core_local_interruptor.sv
`timescale 1ns / 1ps

// Core-local interruptor for two harts: a 64-bit time counter, a 64-bit
// compare value and a software-interrupt bit per hart, and an external
// pending mask of NUM_EXT_IRQS bits. Every input word yields exactly one
// result word. Read, write, set/clear pending and check finish in the cycle
// they are accepted. A tick holds off the next acceptance until its divide
// ends: the widened cycle sum (remainder plus cycle_count, 33 bits) is
// divided by cycles_per_microsecond in a restoring divider at one
// quotient bit per cycle; on the divider's done the quotient is added to
// time and the remainder is stored. The tick's all-zero result is posted at
// acceptance, so the downstream side is never held by the divide. A
// cycles_per_microsecond of zero divides by one. The config port is always
// ready; write it only while the block is idle.
module core_local_interruptor
#(
    parameter int NUM_EXT_IRQS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [31:0] cycle_count,
    input  logic [3:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [7:0]  irq_number,
    input  logic [1:0]  hart_select,
    input  logic        global_enable,
    input  logic [2:0]  enable_mask,
    input  logic        hart_waiting,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [2:0]  pending_bits,
    output logic        wake,
    output logic        take_trap,
    output logic [1:0]  trap_cause
);

    // sequencer: idle takes words, div waits on the divider
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0]             cpu_reg;
    logic [NUM_EXT_IRQS-1:0] ext_en_reg [clint_pkg::NUM_HARTS];

    // architectural state
    logic [63:0]             time_reg;
    logic [63:0]             cmp_reg [clint_pkg::NUM_HARTS];
    logic                    soft_reg [clint_pkg::NUM_HARTS];
    logic [NUM_EXT_IRQS-1:0] ext_pend_reg;
    logic [31:0]             crem_reg;

    // result word
    logic        out_valid_reg;
    logic [31:0] read_data_reg;
    logic [2:0]  pend_reg;
    logic        wake_reg;
    logic        take_reg;
    logic [1:0]  cause_reg;

    logic                    in_fire;
    logic                    cfg_fire;
    logic                    is_tick;
    logic [31:0]             rd_next;
    logic [2:0]              pend_next;
    logic [2:0]              deliver;
    logic                    wake_next;
    logic                    take_next;
    logic [1:0]              cause_next;
    logic                    hart_ok;
    logic                    h;
    logic [NUM_EXT_IRQS-1:0] irq_sel;

    clint_pkg::div_req_t                div_req;
    logic                               div_done;
    logic [clint_pkg::DIVIDEND_W-1:0]   div_quo;
    logic [clint_pkg::DIVISOR_W-1:0]    div_rem;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // the output register may be refilled in the cycle it drains
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign is_tick  = (kind == clint_pkg::KIND_TICK);

    // ---------------------------------------------------------------
    // Divider request: widened sum never wraps, zero divisor acts as one
    // ---------------------------------------------------------------
    always_comb
    begin
        div_req.start    = in_fire && is_tick;
        div_req.dividend = {1'b0, crem_reg} + {1'b0, cycle_count};
        div_req.divisor  = (cpu_reg == 32'd0) ? 32'd1 : cpu_reg;
    end

    clint_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && is_tick)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Register read mux
    // ---------------------------------------------------------------
    always_comb
    begin
        rd_next = 32'd0;
        if (kind == clint_pkg::KIND_READ)
        begin
            case (reg_index)
                clint_pkg::REG_TIME_LO: rd_next = time_reg[31:0];
                clint_pkg::REG_TIME_HI: rd_next = time_reg[63:32];
                clint_pkg::REG_CMP0_LO: rd_next = cmp_reg[0][31:0];
                clint_pkg::REG_CMP0_HI: rd_next = cmp_reg[0][63:32];
                clint_pkg::REG_CMP1_LO: rd_next = cmp_reg[1][31:0];
                clint_pkg::REG_CMP1_HI: rd_next = cmp_reg[1][63:32];
                clint_pkg::REG_SOFT0:   rd_next = {31'd0, soft_reg[0]};
                clint_pkg::REG_SOFT1:   rd_next = {31'd0, soft_reg[1]};
                default:                rd_next = 32'd0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Interrupt check: priority external, software, timer
    // ---------------------------------------------------------------
    always_comb
    begin
        hart_ok    = (hart_select < 2'(clint_pkg::NUM_HARTS));
        h          = hart_select[0];
        pend_next  = 3'd0;
        wake_next  = 1'b0;
        take_next  = 1'b0;
        cause_next = clint_pkg::CAUSE_EXT;
        deliver    = 3'd0;
        if (kind == clint_pkg::KIND_CHECK)
        begin
            if (hart_ok)
            begin
                pend_next[0] = soft_reg[h];
                pend_next[1] = (time_reg >= cmp_reg[h]);
                pend_next[2] = |(ext_pend_reg & ext_en_reg[h]);
            end
            if (global_enable)
                deliver = pend_next & enable_mask;
            wake_next = hart_waiting && (|deliver);
            take_next = |deliver;
            if (deliver[2])
                cause_next = clint_pkg::CAUSE_EXT;
            else if (deliver[0])
                cause_next = clint_pkg::CAUSE_SOFT;
            else if (deliver[1])
                cause_next = clint_pkg::CAUSE_TIMER;
        end
    end

    // one-hot select of the addressed external line; out of range hits none
    always_comb
    begin
        for (int i = 0; i < NUM_EXT_IRQS; i++)
            irq_sel[i] = (irq_number == 8'(i));
    end

    // ---------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cpu_reg       <= 32'd1;
            time_reg      <= 64'd0;
            ext_pend_reg  <= '0;
            crem_reg      <= 32'd0;
            for (int i = 0; i < clint_pkg::NUM_HARTS; i++)
            begin
                ext_en_reg[i] <= '0;
                cmp_reg[i]    <= '1;
                soft_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_fire)
            begin
                case (cfg_index)
                    clint_pkg::CFG_CYCLES_PER_US: cpu_reg <= cfg_data[31:0];
                    clint_pkg::CFG_EXT_EN_HART0:
                        ext_en_reg[0] <= cfg_data[NUM_EXT_IRQS-1:0];
                    clint_pkg::CFG_EXT_EN_HART1:
                        ext_en_reg[1] <= cfg_data[NUM_EXT_IRQS-1:0];
                    default: ;
                endcase
            end

            // end of a tick: advance time, keep the leftover cycles
            if (state_reg == S_DIV && div_done)
            begin
                time_reg <= time_reg + {31'd0, div_quo};
                crem_reg <= div_rem;
            end

            if (in_fire)
            begin
                case (kind)
                    clint_pkg::KIND_WRITE:
                    begin
                        case (reg_index)
                            clint_pkg::REG_TIME_LO: time_reg[31:0]    <= write_data;
                            clint_pkg::REG_TIME_HI: time_reg[63:32]   <= write_data;
                            clint_pkg::REG_CMP0_LO: cmp_reg[0][31:0]  <= write_data;
                            clint_pkg::REG_CMP0_HI: cmp_reg[0][63:32] <= write_data;
                            clint_pkg::REG_CMP1_LO: cmp_reg[1][31:0]  <= write_data;
                            clint_pkg::REG_CMP1_HI: cmp_reg[1][63:32] <= write_data;
                            clint_pkg::REG_SOFT0:   soft_reg[0] <= write_data[0];
                            clint_pkg::REG_SOFT1:   soft_reg[1] <= write_data[0];
                            default: ;
                        endcase
                    end
                    clint_pkg::KIND_SET_PEND: ext_pend_reg <= ext_pend_reg | irq_sel;
                    clint_pkg::KIND_CLR_PEND: ext_pend_reg <= ext_pend_reg & ~irq_sel;
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            read_data_reg <= rd_next;
            pend_reg      <= pend_next;
            wake_reg      <= wake_next;
            take_reg      <= take_next;
            cause_reg     <= cause_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign pending_bits = pend_reg;
    assign wake         = wake_reg;
    assign take_trap    = take_reg;
    assign trap_cause   = cause_reg;

`ifndef ASSERT_OFF
    // no word is taken while a divide is in flight
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !in_ready)
        else $error("input accepted during divide");

    // divider only finishes while the sequencer waits on it
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // an accepted tick starts a divide and posts a result word
    a_tick_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_tick) |=> (state_reg == S_DIV) && out_valid_reg)
        else $error("tick did not start divide");
`endif

endmodule

FILE: test/tb_core_local_interruptor.sv
`timescale 1ns / 1ps

// Testbench for core_local_interruptor.
// Words go in through a valid/ready source and results come back through a
// valid/ready sink. Both sides pause at random. A word-level predictor
// tracks time, the compares, the soft bits, the external pending mask and
// the tick remainder. It works out one expected result per accepted word.
// Each result coming back is compared field by field, oldest first.
module tb_core_local_interruptor;

    localparam int EXT_IRQS        = 64;
    localparam int SETTLE_CYCLES   = 40;    // covers a tick's divide after the last result
    localparam int HOLD_CYCLES     = 300;   // long sink hold-off for the pressure test
    localparam int WORDS_PER_PHASE = 120;
    localparam int IDLE_PCT        = 38;

    // Kinds the block must treat as no-ops
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    // An index past the dense register map
    localparam logic [3:0] REG_UNMAPPED = 4'd15;

    // Hart enable bits as carried in enable_mask
    localparam logic [2:0] EN_SOFT  = 3'b001;
    localparam logic [2:0] EN_TIMER = 3'b010;
    localparam logic [2:0] EN_EXT   = 3'b100;
    localparam logic [2:0] EN_ALL   = EN_SOFT | EN_TIMER | EN_EXT;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] cycles;
        logic [3:0]  idx;
        logic [31:0] wdata;
        logic [7:0]  irq;
        logic [1:0]  hart;
        logic        gie;
        logic [2:0]  en;
        logic        waiting;
    } clint_op_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [2:0]  pend;
        logic        wake;
        logic        take;
        logic [1:0]  cause;
    } clint_rsp_t;

    logic        clk;
    logic        rst_n         = 1'b0;

    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [63:0] cfg_data      = '0;

    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [2:0]  kind          = '0;
    logic [31:0] cycle_count   = '0;
    logic [3:0]  reg_index     = '0;
    logic [31:0] write_data    = '0;
    logic [7:0]  irq_number    = '0;
    logic [1:0]  hart_select   = '0;
    logic        global_enable = 1'b0;
    logic [2:0]  enable_mask   = '0;
    logic        hart_waiting  = 1'b0;

    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [31:0] read_data;
    logic [2:0]  pending_bits;
    logic        wake;
    logic        take_trap;
    logic [1:0]  trap_cause;

    // Predictor copy of the block state and its configuration
    logic [31:0] mdl_cyc_per_us;
    logic [63:0] mdl_ext_en   [clint_pkg::NUM_HARTS];
    logic [63:0] mdl_time;
    logic [63:0] mdl_cmp      [clint_pkg::NUM_HARTS];
    logic        mdl_soft     [clint_pkg::NUM_HARTS];
    logic [63:0] mdl_ext_pend;
    logic [31:0] mdl_rem;

    // Results owed by the block, oldest first
    clint_rsp_t results_due [$];

    int err_count     = 0;
    int words_in      = 0;
    int ticks_in      = 0;
    int checks_in     = 0;
    int traps_out     = 0;
    int wakes_out     = 0;
    int cfg_writes    = 0;
    int src_idle_pct  = IDLE_PCT;
    int sink_idle_pct = IDLE_PCT;

    // Sink hold-off: the test bumps hold_req, the sink process counts it down
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    core_local_interruptor #(
        .NUM_EXT_IRQS (EXT_IRQS)
    ) i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Predictor: applies one word to the local state, returns the result
    // ---------------------------------------------------------------------
    function automatic clint_rsp_t advance_clint(clint_op_t op);
        clint_rsp_t  r;
        logic [32:0] sum;
        logic [32:0] divisor;
        logic [2:0]  deliver;
        int          h;
        r = '0;
        case (op.kind)
            clint_pkg::KIND_TICK:
            begin
                // 33-bit sum so a remainder plus a full count never wraps;
                // a zero divisor counts as one
                divisor = (mdl_cyc_per_us == 32'd0) ? 33'd1 : {1'b0, mdl_cyc_per_us};
                sum     = {1'b0, mdl_rem} + {1'b0, op.cycles};
                if (sum >= divisor)
                begin
                    mdl_time = mdl_time + 64'(sum / divisor);
                    sum      = sum % divisor;
                end
                mdl_rem = sum[31:0];
            end
            clint_pkg::KIND_READ:
            begin
                case (op.idx)
                    clint_pkg::REG_TIME_LO: r.rdata = mdl_time[31:0];
                    clint_pkg::REG_TIME_HI: r.rdata = mdl_time[63:32];
                    clint_pkg::REG_CMP0_LO: r.rdata = mdl_cmp[0][31:0];
                    clint_pkg::REG_CMP0_HI: r.rdata = mdl_cmp[0][63:32];
                    clint_pkg::REG_CMP1_LO: r.rdata = mdl_cmp[1][31:0];
                    clint_pkg::REG_CMP1_HI: r.rdata = mdl_cmp[1][63:32];
                    clint_pkg::REG_SOFT0:   r.rdata = {31'd0, mdl_soft[0]};
                    clint_pkg::REG_SOFT1:   r.rdata = {31'd0, mdl_soft[1]};
                    default:                r.rdata = '0;
                endcase
            end
            clint_pkg::KIND_WRITE:
            begin
                case (op.idx)
                    clint_pkg::REG_TIME_LO: mdl_time[31:0]    = op.wdata;
                    clint_pkg::REG_TIME_HI: mdl_time[63:32]   = op.wdata;
                    clint_pkg::REG_CMP0_LO: mdl_cmp[0][31:0]  = op.wdata;
                    clint_pkg::REG_CMP0_HI: mdl_cmp[0][63:32] = op.wdata;
                    clint_pkg::REG_CMP1_LO: mdl_cmp[1][31:0]  = op.wdata;
                    clint_pkg::REG_CMP1_HI: mdl_cmp[1][63:32] = op.wdata;
                    clint_pkg::REG_SOFT0:   mdl_soft[0]       = op.wdata[0];
                    clint_pkg::REG_SOFT1:   mdl_soft[1]       = op.wdata[0];
                    default:                ;
                endcase
            end
            clint_pkg::KIND_SET_PEND:
            begin
                if (op.irq < EXT_IRQS)
                    mdl_ext_pend[op.irq[5:0]] = 1'b1;
            end
            clint_pkg::KIND_CLR_PEND:
            begin
                if (op.irq < EXT_IRQS)
                    mdl_ext_pend[op.irq[5:0]] = 1'b0;
            end
            clint_pkg::KIND_CHECK:
            begin
                if (op.hart < clint_pkg::NUM_HARTS)
                begin
                    h         = op.hart;
                    r.pend[0] = mdl_soft[h];
                    r.pend[1] = (mdl_time >= mdl_cmp[h]);
                    r.pend[2] = |(mdl_ext_pend & mdl_ext_en[h]);
                end
                // Pending is reported regardless; delivery needs the global enable
                if (op.gie)
                begin
                    deliver = r.pend & op.en;
                    r.wake  = op.waiting && (deliver != 3'd0);
                    if (deliver[2])
                    begin
                        r.take  = 1'b1;
                        r.cause = clint_pkg::CAUSE_EXT;
                    end
                    else if (deliver[0])
                    begin
                        r.take  = 1'b1;
                        r.cause = clint_pkg::CAUSE_SOFT;
                    end
                    else if (deliver[1])
                    begin
                        r.take  = 1'b1;
                        r.cause = clint_pkg::CAUSE_TIMER;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Word builders. Fields a kind does not use still carry random bits.
    // ---------------------------------------------------------------------
    function automatic clint_op_t noise_op();
        clint_op_t op;
        op.kind    = 3'($urandom);
        op.cycles  = $urandom;
        op.idx     = 4'($urandom);
        op.wdata   = $urandom;
        op.irq     = 8'($urandom);
        op.hart    = 2'($urandom);
        op.gie     = 1'($urandom);
        op.en      = 3'($urandom);
        op.waiting = 1'($urandom);
        return op;
    endfunction

    function automatic clint_op_t op_tick(logic [31:0] cycles);
        clint_op_t op;
        op        = noise_op();
        op.kind   = clint_pkg::KIND_TICK;
        op.cycles = cycles;
        return op;
    endfunction

    function automatic clint_op_t op_read(logic [3:0] idx);
        clint_op_t op;
        op      = noise_op();
        op.kind = clint_pkg::KIND_READ;
        op.idx  = idx;
        return op;
    endfunction

    function automatic clint_op_t op_write(logic [3:0] idx, logic [31:0] wdata);
        clint_op_t op;
        op       = noise_op();
        op.kind  = clint_pkg::KIND_WRITE;
        op.idx   = idx;
        op.wdata = wdata;
        return op;
    endfunction

    function automatic clint_op_t op_irq(logic [2:0] k, logic [7:0] irq);
        clint_op_t op;
        op      = noise_op();
        op.kind = k;
        op.irq  = irq;
        return op;
    endfunction

    function automatic clint_op_t op_check(logic [1:0] hart, logic gie, logic [2:0] en,
                                           logic waiting);
        clint_op_t op;
        op         = noise_op();
        op.kind    = clint_pkg::KIND_CHECK;
        op.hart    = hart;
        op.gie     = gie;
        op.en      = en;
        op.waiting = waiting;
        return op;
    endfunction

    // Random word, biased toward mapped registers, live harts, in-range
    // lines, and values that put time close to the compares
    function automatic clint_op_t random_op();
        clint_op_t   op;
        int unsigned pick;
        logic [31:0] unit;
        op   = noise_op();
        unit = (mdl_cyc_per_us == 32'd0) ? 32'd1 : mdl_cyc_per_us;
        pick = $urandom_range(99);
        if (pick < 22)
            op.kind = clint_pkg::KIND_TICK;
        else if (pick < 38)
            op.kind = clint_pkg::KIND_READ;
        else if (pick < 58)
            op.kind = clint_pkg::KIND_WRITE;
        else if (pick < 69)
            op.kind = clint_pkg::KIND_SET_PEND;
        else if (pick < 77)
            op.kind = clint_pkg::KIND_CLR_PEND;
        else if (pick < 97)
            op.kind = clint_pkg::KIND_CHECK;
        else
            op.kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;

        if ($urandom_range(9) != 0)
            op.idx = 4'($urandom_range(7));
        if ($urandom_range(7) != 0)
            op.irq = 8'($urandom_range(EXT_IRQS - 1));
        if ($urandom_range(7) != 0)
            op.hart = 2'($urandom_range(clint_pkg::NUM_HARTS - 1));
        if ($urandom_range(3) != 0)
            op.gie = 1'b1;

        // Mostly a few time units per tick so time creeps across compares
        if (op.kind == clint_pkg::KIND_TICK && unit <= 32'd1_000_000 &&
            $urandom_range(3) != 0)
            op.cycles = $urandom_range(4 * unit);

        if (op.kind == clint_pkg::KIND_WRITE && $urandom_range(1) != 0)
        begin
            case (op.idx)
                clint_pkg::REG_CMP0_HI, clint_pkg::REG_CMP1_HI:
                    op.wdata = mdl_time[63:32];
                clint_pkg::REG_CMP0_LO, clint_pkg::REG_CMP1_LO,
                clint_pkg::REG_TIME_LO:
                    op.wdata = mdl_time[31:0] + 32'($urandom_range(16)) - 32'd4;
                default: ;
            endcase
        end
        return op;
    endfunction

    // ---------------------------------------------------------------------
    // Source side
    // ---------------------------------------------------------------------
    // Valid stays high across back-to-back words; it only drops for a gap.
    task automatic send_word(input clint_op_t op);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        kind          <= op.kind;
        cycle_count   <= op.cycles;
        reg_index     <= op.idx;
        write_data    <= op.wdata;
        irq_number    <= op.irq;
        hart_select   <= op.hart;
        global_enable <= op.gie;
        enable_mask   <= op.en;
        hart_waiting  <= op.waiting;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drain: stop offering, wait for every owed result, then let a tick's
    // divide finish so the block is truly idle
    task automatic settle();
        int waited = 0;
        in_valid <= 1'b0;
        while (results_due.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three config registers back to back; only while idle
    task automatic apply_settings(input logic [31:0] cyc_per_us, input logic [63:0] en0,
                                  input logic [63:0] en1);
        logic [1:0]  regs   [3];
        logic [63:0] values [3];
        regs   = '{clint_pkg::CFG_CYCLES_PER_US, clint_pkg::CFG_EXT_EN_HART0,
                   clint_pkg::CFG_EXT_EN_HART1};
        values = '{{32'd0, cyc_per_us}, en0, en1};
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= values[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_writes++;
        end
        cfg_valid      <= 1'b0;
        mdl_cyc_per_us  = cyc_per_us;
        mdl_ext_en[0]   = en0;
        mdl_ext_en[1]   = en1;
    endtask

    // ---------------------------------------------------------------------
    // Sink pacing: random stalls, plus a long hold when a test asks for one
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : sink_pacing
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ---------------------------------------------------------------------
    // Predict on input acceptance, then compare on output acceptance.
    // Input is handled first so a same-edge result finds its expectation.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        clint_op_t  seen;
        clint_rsp_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                seen.kind    = kind;
                seen.cycles  = cycle_count;
                seen.idx     = reg_index;
                seen.wdata   = write_data;
                seen.irq     = irq_number;
                seen.hart    = hart_select;
                seen.gie     = global_enable;
                seen.en      = enable_mask;
                seen.waiting = hart_waiting;
                results_due.push_back(advance_clint(seen));
                words_in++;
                if (kind == clint_pkg::KIND_TICK)
                    ticks_in++;
                if (kind == clint_pkg::KIND_CHECK)
                    checks_in++;
            end
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    err_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("read_data", want.rdata, read_data);
                    check_field("pending_bits", 32'(want.pend), 32'(pending_bits));
                    check_field("wake", 32'(want.wake), 32'(wake));
                    check_field("take_trap", 32'(want.take), 32'(take_trap));
                    check_field("trap_cause", 32'(want.cause), 32'(trap_cause));
                    if (take_trap === 1'b1)
                        traps_out++;
                    if (wake === 1'b1)
                        wakes_out++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // Reset values: time zero, compares all ones, soft bits clear
    task automatic test_reset_state();
        settle();
        send_word(op_read(clint_pkg::REG_TIME_HI));
        send_word(op_read(clint_pkg::REG_CMP1_HI));
        send_word(op_read(clint_pkg::REG_SOFT1));
        send_word(op_check(2'd0, 1'b1, EN_ALL, 1'b1));
    endtask

    // Divider corners: zero divisor, full-width counts, remainder left
    // above a newly lowered divisor, and a sum that needs the 33rd bit
    task automatic test_tick_division();
        settle();
        apply_settings(32'd0, '1, '0);
        send_word(op_tick(32'hFFFF_FFFF));
        send_word(op_tick(32'd0));
        settle();
        apply_settings(32'd1000, '1, '0);
        send_word(op_tick(32'd999));
        settle();
        apply_settings(32'd10, '1, '0);
        send_word(op_tick(32'd5));
        settle();
        apply_settings(32'hFFFF_FFFF, '1, '0);
        send_word(op_tick(32'hFFFF_FFFF));
        send_word(op_read(clint_pkg::REG_TIME_LO));
    endtask

    // Half-word writes, time wrap through a tick, soft bit takes bit 0 only,
    // unmapped index ignored on write and zero on read
    task automatic test_register_access();
        send_word(op_write(clint_pkg::REG_TIME_LO, 32'hFFFF_FFFF));
        send_word(op_write(clint_pkg::REG_TIME_HI, 32'hFFFF_FFFF));
        send_word(op_tick(32'hFFFF_FFFF));
        send_word(op_write(clint_pkg::REG_SOFT0, 32'hFFFF_FFFE));
        send_word(op_write(clint_pkg::REG_SOFT1, 32'h0000_0001));
        send_word(op_write(REG_UNMAPPED, 32'hFFFF_FFFF));
        send_word(op_read(REG_UNMAPPED));
    endtask

    // Priority, global enable off, wake, out-of-range lines and harts
    task automatic test_interrupt_delivery();
        clint_op_t spare;
        spare      = noise_op();
        spare.kind = KIND_SPARE_B;
        settle();
        apply_settings(32'd1, '1, 64'h8000_0000_0000_0000);
        send_word(op_irq(clint_pkg::KIND_SET_PEND, 8'd0));
        send_word(op_irq(clint_pkg::KIND_SET_PEND, 8'd63));
        send_word(op_irq(clint_pkg::KIND_SET_PEND, 8'd255));  // no such line
        send_word(op_check(2'd0, 1'b1, EN_ALL, 1'b1));        // external first, wakes
        send_word(op_irq(clint_pkg::KIND_CLR_PEND, 8'd63));
        send_word(op_check(2'd1, 1'b1, EN_ALL, 1'b1));        // soft is next
        send_word(op_check(2'd1, 1'b0, EN_ALL, 1'b1));        // reported, not taken
        send_word(op_write(clint_pkg::REG_CMP1_HI, 32'd0));
        send_word(op_write(clint_pkg::REG_CMP1_LO, 32'd0));
        send_word(op_write(clint_pkg::REG_SOFT1, 32'd0));
        send_word(op_check(2'd1, 1'b1, EN_TIMER, 1'b0));      // timer alone, no wake
        send_word(op_check(2'd3, 1'b1, EN_ALL, 1'b1));        // no such hart
        send_word(spare);
    endtask

    // Random words under several configurations, corners included;
    // one phase runs with no pauses on either side
    task automatic test_random_phases();
        logic [31:0] cyc [6];
        logic [63:0] en0 [6];
        logic [63:0] en1 [6];
        cyc = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'($urandom_range(16, 2)), $urandom, 32'd3};
        en0 = '{'1, '0, {$urandom, $urandom}, {$urandom, $urandom}, '1, {$urandom, $urandom}};
        en1 = '{'0, '1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, '1};
        for (int p = 0; p < 6; p++)
        begin
            settle();
            apply_settings(cyc[p], en0[p], en1[p]);
            src_idle_pct  = (p == 2) ? 0 : IDLE_PCT;
            sink_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            repeat (WORDS_PER_PHASE) send_word(random_op());
        end
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
    endtask

    // Sink holds off for a long stretch while the source keeps pushing,
    // so the block fills and must stall its input
    task automatic test_backpressure();
        settle();
        src_idle_pct = 0;
        hold_req++;
        repeat (30) send_word(random_op());
        src_idle_pct = IDLE_PCT;
    endtask

    initial
    begin : main_seq
        mdl_cyc_per_us = 32'd1;
        mdl_ext_en[0]  = '0;
        mdl_ext_en[1]  = '0;
        mdl_time       = '0;
        mdl_cmp[0]     = '1;
        mdl_cmp[1]     = '1;
        mdl_soft[0]    = 1'b0;
        mdl_soft[1]    = 1'b0;
        mdl_ext_pend   = '0;
        mdl_rem        = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_tick_division();
        test_register_access();
        test_interrupt_delivery();
        test_random_phases();
        test_backpressure();
        settle();

        if (results_due.size() != 0)
        begin
            $error("%0d expected result words never arrived", results_due.size());
            err_count++;
        end

        $display("Covered %0d words (%0d ticks, %0d checks) across %0d config writes,",
                 words_in, ticks_in, checks_in, cfg_writes);
        $display("seeing %0d traps and %0d wakes, including a %0d-cycle output hold.",
                 traps_out, wakes_out, HOLD_CYCLES);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #4_000_000;
        $error("run did not finish in time");
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/clint_pkg.sv
rtl/clint_div.sv
rtl/core_local_interruptor.sv
test/tb_core_local_interruptor.sv
